// File: sv/utf8sd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8sd_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int CP_W            = 21;
  localparam int OUT_CNT_W       = 16;
  localparam int LIMIT_W         = 16;
  localparam int RQ_DEPTH        = 4;
  localparam int RQ_AW           = 2;
  localparam int RQ_CW           = 3;

  localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_STRAY     = 2'd1,
    ST_TRUNCATED = 2'd2,
    ST_BAD_LEAD  = 2'd3
  } status_t;

  typedef struct packed {
    logic [CP_W-1:0]      code_point;
    logic [2:0]           seq_length;
    status_t              status;
    logic [OUT_CNT_W-1:0] char_index;
    logic [OUT_CNT_W-1:0] byte_offset;
    logic                 limit_reached;
    logic                 last_of_item;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage
`default_nettype wire

// File: sv/utf8sd_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8sd_decode
// Input register, sequence state and single-pass decode of one byte into
// up to two results.
// ----------------------------------------------------------------------------
module utf8sd_decode
  import utf8sd_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_data_byte,
  input  wire logic               in_start_of_text,
  input  wire logic [LIMIT_W-1:0] char_limit,
  input  wire logic               room,
  output push_t                   push
);

  typedef enum logic [2:0] {
    LK_ASCII,
    LK_CONT,
    LK_LEAD2,
    LK_LEAD3,
    LK_LEAD4,
    LK_BAD
  } lead_kind_t;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic                   s1_valid_r;
  logic [7:0]             s1_byte_r;
  logic                   s1_sot_r;
  logic                   fire;

  logic [1:0]             due_r, due_c, due_nxt;
  logic [CP_W-1:0]        pv_r, pv_c, pv_nxt;
  logic [2:0]             len_r, len_c, len_nxt;
  logic [COUNT_WIDTH-1:0] cc_r, cc_c, cc_nxt;
  logic [COUNT_WIDTH-1:0] bc_r, bc_c, bc_nxt;
  logic [COUNT_WIDTH-1:0] sso_r, sso_c, sso_nxt;

  logic [31:0]            cur_ext, cc_ext, cc_inc_ext, sso_ext;
  logic                   cc_sat, ok_lim;
  lead_kind_t             kind;
  logic                   is_cont;
  logic [CP_W-1:0]        pv_shift;
  logic                   ok_emit;
  result_t                lead_res, r0, r1;
  logic                   lead_emit;
  logic [1:0]             n_res;

  assign fire     = s1_valid_r && room;
  assign in_ready = !s1_valid_r || room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_data_byte;
      s1_sot_r  <= in_start_of_text;
    end
  end

  always_comb begin
    due_c = s1_sot_r ? '0 : due_r;
    pv_c  = s1_sot_r ? '0 : pv_r;
    len_c = s1_sot_r ? '0 : len_r;
    cc_c  = s1_sot_r ? '0 : cc_r;
    bc_c  = s1_sot_r ? '0 : bc_r;
    sso_c = s1_sot_r ? '0 : sso_r;
  end

  assign cur_ext    = 32'(bc_c);
  assign sso_ext    = 32'(sso_c);
  assign cc_ext     = 32'(cc_c);
  assign cc_inc_ext = 32'(cc_c) + 32'd1;
  assign cc_sat     = (cc_c == CNT_MAX);
  assign ok_lim     = !cc_sat && (char_limit != '0) && (cc_inc_ext == 32'(char_limit));
  assign is_cont    = (s1_byte_r[7:6] == 2'b10);
  assign pv_shift   = {pv_c[CP_W-7:0], s1_byte_r[5:0]};

  always_comb begin
    if (!s1_byte_r[7])      kind = LK_ASCII;
    else if (!s1_byte_r[6]) kind = LK_CONT;
    else if (!s1_byte_r[5]) kind = LK_LEAD2;
    else if (!s1_byte_r[4]) kind = LK_LEAD3;
    else if (!s1_byte_r[3]) kind = LK_LEAD4;
    else                    kind = LK_BAD;
  end

  // lead-byte path, also taken after a truncated sequence
  always_comb begin
    lead_res               = '0;
    lead_res.char_index    = cc_ext[OUT_CNT_W-1:0];
    lead_res.byte_offset   = cur_ext[OUT_CNT_W-1:0];
    lead_res.seq_length    = 3'd1;
    lead_res.code_point    = CP_REPLACEMENT;
    lead_emit              = 1'b1;
    case (kind)
      LK_ASCII: begin
        lead_res.code_point    = {{(CP_W-8){1'b0}}, s1_byte_r};
        lead_res.status        = ST_OK;
        lead_res.limit_reached = ok_lim;
      end
      LK_CONT:  lead_res.status = ST_STRAY;
      LK_BAD:   lead_res.status = ST_BAD_LEAD;
      default:  lead_emit = 1'b0;
    endcase
  end

  always_comb begin
    r0      = lead_res;
    r1      = lead_res;
    n_res   = {1'b0, lead_emit};
    ok_emit = lead_emit && (kind == LK_ASCII);
    due_nxt = due_c;
    pv_nxt  = pv_c;
    len_nxt = len_c;
    sso_nxt = sso_c;
    if (due_c != 2'd0 && is_cont) begin
      ok_emit = 1'b0;
      n_res   = 2'd0;
      due_nxt = due_c - 2'd1;
      pv_nxt  = pv_shift;
      if (due_c == 2'd1) begin
        ok_emit          = 1'b1;
        n_res            = 2'd1;
        r0               = '0;
        r0.code_point    = pv_shift;
        r0.seq_length    = len_c;
        r0.status        = ST_OK;
        r0.char_index    = cc_ext[OUT_CNT_W-1:0];
        r0.byte_offset   = sso_ext[OUT_CNT_W-1:0];
        r0.limit_reached = ok_lim;
        pv_nxt           = '0;
        len_nxt          = '0;
      end
    end else begin
      if (due_c != 2'd0) begin
        r0             = '0;
        r0.code_point  = CP_REPLACEMENT;
        r0.seq_length  = 3'd1;
        r0.status      = ST_TRUNCATED;
        r0.char_index  = cc_ext[OUT_CNT_W-1:0];
        r0.byte_offset = sso_ext[OUT_CNT_W-1:0];
        n_res          = lead_emit ? 2'd2 : 2'd1;
      end
      due_nxt = '0;
      pv_nxt  = '0;
      len_nxt = '0;
      case (kind)
        LK_LEAD2: begin
          pv_nxt  = {{(CP_W-5){1'b0}}, s1_byte_r[4:0]};
          due_nxt = 2'd1;
          len_nxt = 3'd2;
          sso_nxt = bc_c;
        end
        LK_LEAD3: begin
          pv_nxt  = {{(CP_W-4){1'b0}}, s1_byte_r[3:0]};
          due_nxt = 2'd2;
          len_nxt = 3'd3;
          sso_nxt = bc_c;
        end
        LK_LEAD4: begin
          pv_nxt  = {{(CP_W-3){1'b0}}, s1_byte_r[2:0]};
          due_nxt = 2'd3;
          len_nxt = 3'd4;
          sso_nxt = bc_c;
        end
        default: ;
      endcase
    end
    cc_nxt = (ok_emit && !cc_sat) ? cc_c + 1'b1 : cc_c;
    bc_nxt = (bc_c == CNT_MAX) ? bc_c : bc_c + 1'b1;
    if (n_res == 2'd2) r1.last_of_item = 1'b1;
    else               r0.last_of_item = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      due_r <= '0;
      pv_r  <= '0;
      len_r <= '0;
      cc_r  <= '0;
      bc_r  <= '0;
      sso_r <= '0;
    end else if (fire) begin
      due_r <= due_nxt;
      pv_r  <= pv_nxt;
      len_r <= len_nxt;
      cc_r  <= cc_nxt;
      bc_r  <= bc_nxt;
      sso_r <= sso_nxt;
    end
  end

  assign push.cnt  = fire ? n_res : 2'd0;
  assign push.res0 = r0;
  assign push.res1 = r1;

endmodule
`default_nettype wire

// File: sv/utf8sd_rq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8sd_rq
// Result queue: takes up to two results a cycle with room, hands out one a cycle on out_ready.
// ----------------------------------------------------------------------------
module utf8sd_rq
  import utf8sd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  push_t      push,
  output logic       room,
  output logic       out_valid,
  input  wire logic  out_ready,
  output result_t    out_res
);

  result_t          mem_r [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RQ_CW-1:0] count_r, count_nxt;
  logic             pop;
  logic [RQ_AW-1:0] wr_ptr_p1;

  assign room      = (count_r <= RQ_CW'(RQ_DEPTH - 2));
  assign out_valid = (count_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + RQ_AW'(push.cnt);
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + RQ_CW'(push.cnt) - RQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem_r[wr_ptr_r]  <= push.res0;
    if (push.cnt == 2'd2) mem_r[wr_ptr_p1] <= push.res1;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= RQ_CW'(RQ_DEPTH))
    else $error("result queue overflow");

  assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> room)
    else $error("push without room");

endmodule
`default_nettype wire

// File: sv/utf8_stream_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Byte-serial UTF-8 decoder and validator with character limit flag.
//
//   channel | ports                                    | dir
//   --------+------------------------------------------+----
//   in      | in_valid/in_ready, data_byte, sot        | in
//   out     | out_valid/out_ready, result fields       | out
//   cfg     | cfg_valid/cfg_ready, cfg_char_limit      | in
//
// One byte per cycle while the queue has room; a request passes the input
// register and the combinational decode and lands in a 4-entry result queue,
// which registers it before out_valid rises. A byte giving two results leaves
// one extra entry behind; with out ready it can stall the input once the
// queue passes half full. Reset is synchronous, active low; it clears state,
// counters and queue. Stalls on out hold the queue and, once it is more than
// half full, the input.
// ----------------------------------------------------------------------------
module utf8_stream_decoder
  import utf8sd_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_data_byte,
  input  wire logic               in_start_of_text,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [CP_W-1:0]         out_code_point,
  output logic [2:0]              out_seq_length,
  output logic [1:0]              out_status,
  output logic [OUT_CNT_W-1:0]    out_char_index,
  output logic [OUT_CNT_W-1:0]    out_byte_offset,
  output logic                    out_limit_reached,
  output logic                    out_last_of_item,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [LIMIT_W-1:0] cfg_char_limit
);

  logic [LIMIT_W-1:0] char_limit_r;
  push_t              push;
  logic               room;
  result_t            out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_limit_r <= '0;
    end else if (cfg_valid) begin
      char_limit_r <= cfg_char_limit;
    end
  end

  utf8sd_decode #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_decode (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_start_of_text (in_start_of_text),
    .char_limit       (char_limit_r),
    .room             (room),
    .push             (push)
  );

  utf8sd_rq u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_code_point    = out_res.code_point;
  assign out_seq_length    = out_res.seq_length;
  assign out_status        = out_res.status;
  assign out_char_index    = out_res.char_index;
  assign out_byte_offset   = out_res.byte_offset;
  assign out_limit_reached = out_res.limit_reached;
  assign out_last_of_item  = out_res.last_of_item;

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_code_point == CP_REPLACEMENT && out_seq_length == 3'd1 && !out_limit_reached))
    else $error("error result with bad fields");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OK) |->
      (out_seq_length != 3'd0 && out_seq_length <= 3'd4))
    else $error("ok result with bad length");

  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule
`default_nettype wire
